### rtl/kmc_pkg.sv
// ----------------------------------------------------------------------------
// kmc_pkg
// Shared types, constants and the base decoder of the k-mer occurrence counter.
// ----------------------------------------------------------------------------
package kmc_pkg;

    // Fixed widths of the external fields.
    localparam int KSIZE_W    = 4;
    localparam int POS_W      = 32;
    localparam int CODE_W     = 20;
    localparam int COUNT_W    = 32;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [KSIZE_W-1:0] KSIZE_RESET = 4'd10;
    localparam logic [KSIZE_W-1:0] RUN_MAX     = 4'd15;

    // Register index, taken from the word address bits of paddr.
    localparam logic REG_KMER_SIZE = 1'b0;

    // Opcodes of the input word.
    localparam logic OP_COUNT = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // ASCII codes of the four bases, both cases.
    localparam logic [7:0] CH_A_UP = 8'h41;
    localparam logic [7:0] CH_C_UP = 8'h43;
    localparam logic [7:0] CH_G_UP = 8'h47;
    localparam logic [7:0] CH_T_UP = 8'h54;
    localparam logic [7:0] CH_A_LO = 8'h61;
    localparam logic [7:0] CH_C_LO = 8'h63;
    localparam logic [7:0] CH_G_LO = 8'h67;
    localparam logic [7:0] CH_T_LO = 8'h74;

    localparam logic [1:0] BASE_A = 2'd0;
    localparam logic [1:0] BASE_C = 2'd1;
    localparam logic [1:0] BASE_G = 2'd2;
    localparam logic [1:0] BASE_T = 2'd3;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FWD,
        ST_REV,
        ST_QRY
    } t_state;

    typedef struct packed {
        logic       ok;
        logic [1:0] code;
    } t_base;

    // Status of the window after the base of the current word.
    typedef struct packed {
        logic base_ok;
        logic full;
    } t_win_flags;

    function automatic t_base base_code(input logic [7:0] ch);
        t_base b;
        b.ok = 1'b1;
        case (ch)
            CH_A_UP, CH_A_LO: b.code = BASE_A;
            CH_C_UP, CH_C_LO: b.code = BASE_C;
            CH_G_UP, CH_G_LO: b.code = BASE_G;
            CH_T_UP, CH_T_LO: b.code = BASE_T;
            default: begin
                b.ok   = 1'b0;
                b.code = BASE_A;
            end
        endcase
        return b;
    endfunction

endpackage

### rtl/kmc_table.sv
// ----------------------------------------------------------------------------
// kmc_table
// Count table: one write port, one registered read port, write-first on a
// same-address collision.
// ----------------------------------------------------------------------------
module kmc_table #(
    parameter int AW = 20,
    parameter int DW = 32
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [2**AW];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // The read data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            if (i_we && (i_waddr == i_raddr)) begin
                r_rdata <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_raddr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/kmc_window.sv
// ----------------------------------------------------------------------------
// kmc_window
// Rolling forward and reverse-complement windows, run length and position.
// Gives the table keys of the word being accepted.
// ----------------------------------------------------------------------------
module kmc_window #(
    parameter int MAX_KMER = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_take,
    input  logic                          i_first,
    input  logic [7:0]                    i_base_char,
    input  logic [kmc_pkg::KSIZE_W-1:0]   i_kmer_size,
    output logic [2*MAX_KMER-1:0]         o_fwd_key,
    output logic [2*MAX_KMER-1:0]         o_rev_key,
    output logic [kmc_pkg::POS_W-1:0]     o_start,
    output kmc_pkg::t_win_flags           o_flags
);
    import kmc_pkg::*;

    localparam int TW = 2 * MAX_KMER;

    logic [TW-1:0]      r_fwd, r_rev;
    logic [KSIZE_W-1:0] r_run;
    logic [POS_W-1:0]   r_pos;

    logic [TW-1:0]      fwd_base, rev_base, fwd_new, rev_new, key_mask;
    logic [KSIZE_W-1:0] run_base, run_new, k, k_diff;
    logic [KSIZE_W:0]   shamt;
    logic [POS_W-1:0]   pos_base;
    t_base              b;

    always_comb begin
        b        = base_code(i_base_char);
        fwd_base = i_first ? '0 : r_fwd;
        rev_base = i_first ? '0 : r_rev;
        run_base = i_first ? '0 : r_run;
        pos_base = i_first ? '0 : r_pos;

        // Newest base enters the low end of the forward window and, as its
        // complement, the high end of the reverse window.
        fwd_new = TW'({fwd_base, b.code});
        rev_new = TW'({~b.code, rev_base} >> 2);
        run_new = (run_base == RUN_MAX) ? run_base : run_base + KSIZE_W'(1);

        if (i_kmer_size == '0) begin
            k = KSIZE_W'(1);
        end else if (i_kmer_size > KSIZE_W'(MAX_KMER)) begin
            k = KSIZE_W'(MAX_KMER);
        end else begin
            k = i_kmer_size;
        end
        k_diff   = KSIZE_W'(MAX_KMER) - k;
        shamt    = {k_diff, 1'b0};
        key_mask = {TW{1'b1}} >> shamt;

        o_fwd_key     = fwd_new & key_mask;
        o_rev_key     = rev_new >> shamt;
        o_start       = pos_base - POS_W'(k) + POS_W'(1);
        o_flags.base_ok = b.ok;
        o_flags.full    = b.ok && (run_new >= k);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= '0;
            r_rev <= '0;
            r_run <= '0;
            r_pos <= '0;
        end else if (i_take) begin
            r_pos <= pos_base + POS_W'(1);
            if (b.ok) begin
                r_fwd <= fwd_new;
                r_rev <= rev_new;
                r_run <= run_new;
            end else begin
                r_fwd <= '0;
                r_rev <= '0;
                r_run <= '0;
            end
        end
    end

endmodule

### rtl/kmer_occurrence_counter.sv
// ----------------------------------------------------------------------------
// kmer_occurrence_counter
// Counts forward and reverse-complement k-mers of a nucleotide stream in a
// table memory and looks up the count of the k-mer ending at a base.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                  Payload
//  -------   ---------  -------------------------  -----------------------------
//  in        sink       i_in_valid / o_in_stall    opcode, first_of_sequence,
//                                                  base_char
//  out       source     o_out_valid / i_out_stall  start_position, kmer_code,
//                                                  occurrence_count, repeated
//  apb       slave      psel / penable / pready    kmer_size at byte address 0
//
//  A count word with a full window: the accept cycle reads the forward entry,
//  the next cycle writes it back and reads the reverse entry, and the reverse
//  write-back overlaps the accept of the next word. The single read port and
//  single write port of the count table force this split. A query word reads
//  the table at its accept and then waits in the lookup state while the output
//  register still holds an untaken word. A word that fills no window, or
//  carries another character, is done at its accept. After reset the table is
//  cleared one entry per cycle over all 4**MAX_KMER entries (1,048,576 at the
//  default), and no input word is accepted during that pass; configuration
//  writes are taken throughout.
// ----------------------------------------------------------------------------
module kmer_occurrence_counter #(
    parameter int MAX_KMER   = 10,
    parameter int COUNT_BITS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_opcode,
    input  logic                              i_first_of_sequence,
    input  logic [7:0]                        i_base_char,

    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [kmc_pkg::POS_W-1:0]         o_start_position,
    output logic [kmc_pkg::CODE_W-1:0]        o_kmer_code,
    output logic [kmc_pkg::COUNT_W-1:0]       o_occurrence_count,
    output logic                              o_repeated,

    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [kmc_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [kmc_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [kmc_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import kmc_pkg::*;

    localparam int TW = 2 * MAX_KMER;

    // Configuration register. Only the word address bits select a register.
    logic [KSIZE_W-1:0] r_kmer_size;
    logic               reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[APB_ADDR_W-1:2] == REG_KMER_SIZE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kmer_size <= KSIZE_RESET;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            r_kmer_size <= pwdata[KSIZE_W-1:0];
        end
    end

    assign prdata = reg_sel ? APB_DATA_W'(r_kmer_size) : '0;

    // Window tracking.
    logic              in_take;
    logic [TW-1:0]     fwd_key, rev_key;
    logic [POS_W-1:0]  start_pos;
    t_win_flags        win_flags;

    kmc_window #(
        .MAX_KMER (MAX_KMER)
    ) u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (in_take),
        .i_first     (i_first_of_sequence),
        .i_base_char (i_base_char),
        .i_kmer_size (r_kmer_size),
        .o_fwd_key   (fwd_key),
        .o_rev_key   (rev_key),
        .o_start     (start_pos),
        .o_flags     (win_flags)
    );

    // Count table.
    logic                  mem_we, mem_re;
    logic [TW-1:0]         mem_waddr, mem_raddr;
    logic [COUNT_BITS-1:0] mem_wdata, mem_rdata, count_inc;

    kmc_table #(
        .AW (TW),
        .DW (COUNT_BITS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Saturating increment of the count just read.
    assign count_inc = (mem_rdata == {COUNT_BITS{1'b1}}) ? mem_rdata
                                                         : mem_rdata + COUNT_BITS'(1);

    // Sequencer state and the keys of the word in flight.
    t_state           r_state, n_state;
    logic [TW-1:0]    r_clr_addr, r_fwd_addr, r_rev_addr;
    logic [POS_W-1:0] r_start;
    logic             hit;
    logic             out_free, out_load;

    assign hit      = win_flags.full;
    assign out_free = !o_out_valid || !i_out_stall;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == {TW{1'b1}}) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE, ST_REV: begin
                if (in_take && hit) begin
                    n_state = (i_opcode == OP_QUERY) ? ST_QRY : ST_FWD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_FWD: begin
                n_state = ST_REV;
            end
            ST_QRY: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Handshake and table port control.
    always_comb begin
        o_in_stall = 1'b1;
        in_take    = 1'b0;
        out_load   = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = r_fwd_addr;
        mem_wdata  = count_inc;
        mem_re     = 1'b0;
        mem_raddr  = fwd_key;
        case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_addr;
                mem_wdata = '0;
            end
            ST_IDLE: begin
                o_in_stall = 1'b0;
                in_take    = i_in_valid;
                mem_re     = i_in_valid && hit;
            end
            ST_FWD: begin
                // Forward write-back; a palindrome reads its own new value
                // through the table's write-first path.
                mem_we    = 1'b1;
                mem_re    = 1'b1;
                mem_raddr = r_rev_addr;
            end
            ST_REV: begin
                o_in_stall = 1'b0;
                in_take    = i_in_valid;
                mem_re     = i_in_valid && hit;
                mem_we     = 1'b1;
                mem_waddr  = r_rev_addr;
            end
            ST_QRY: begin
                out_load = out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + TW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_fwd_addr <= fwd_key;
            r_rev_addr <= rev_key;
            r_start    <= start_pos;
        end
    end

    // Output register; a query result waits here while the next word enters.
    logic                 r_out_valid;
    logic [POS_W-1:0]     r_out_start;
    logic [CODE_W-1:0]    r_out_code;
    logic [COUNT_W-1:0]   r_out_count;
    logic                 r_out_rep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_start <= r_start;
            r_out_code  <= CODE_W'(r_fwd_addr);
            r_out_count <= COUNT_W'(mem_rdata);
            r_out_rep   <= (mem_rdata > COUNT_BITS'(1));
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_start_position   = r_out_start;
    assign o_kmer_code        = r_out_code;
    assign o_occurrence_count = r_out_count;
    assign o_repeated         = r_out_rep;

`ifndef SYNTHESIS
    a_no_take_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> o_in_stall)
        else $error("input word accepted during table clear");

    a_fwd_then_rev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FWD) |=> (r_state == ST_REV))
        else $error("reverse write-back did not follow forward write-back");

    a_rev_after_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_REV) |-> ($past(r_state) == ST_FWD))
        else $error("reverse write-back without forward write-back");

    a_query_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_QRY && o_out_valid && i_out_stall) |=> (r_state == ST_QRY))
        else $error("query result dropped while output was stalled");

    a_repeated_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_repeated == (o_occurrence_count > COUNT_W'(1))))
        else $error("repeated flag disagrees with count");
`endif

endmodule

### tb/kmer_occurrence_counter_tb.sv
// ----------------------------------------------------------------------------
// kmer_occurrence_counter_tb
// Self-checking testbench of the k-mer occurrence counter. Words are driven
// through the valid/stall input channel. A scoreboard object follows the
// rolling windows and the count table, and it predicts every query lookup.
// Each lookup that the block hands out is checked against the oldest
// prediction. The k-mer size register is written over APB between phases.
// ----------------------------------------------------------------------------
module kmer_occurrence_counter_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import kmc_pkg::*;

    localparam int MAX_KMER    = 10;
    localparam int COUNT_BITS  = 32;
    localparam int WIN_W       = 2 * MAX_KMER;
    localparam int TABLE_DEPTH = 1 << WIN_W;
    localparam int ADDR_W      = APB_ADDR_W;

    // The register list holds one entry. Index 1 lies past its end.
    localparam int REG_UNUSED = 1;

    localparam int CLK_PERIOD = 20;
    localparam int RESET_CYCLES = 10;
    // The block clears its 2**20 entry table after reset.
    // The limit covers that pass and the whole stimulus several times over.
    localparam longint TIMEOUT_NS = 64'd100_000_000;
    // Cycles to let pass after the last lookup, so that a word that gives no
    // lookup (a count word with its two table updates) has fully retired.
    localparam int TAIL_CYCLES  = 8;
    localparam int SETTLE_LIMIT = 20000;
    localparam int HOLD_CYCLES  = 400;
    localparam int WORDS_PER_PHASE = 190;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [POS_W-1:0]   start_pos;
        logic [CODE_W-1:0]  kmer;
        logic [COUNT_W-1:0] hits;
        logic               repeated;
    } t_lookup;

    // ------------------------------------------------------------------------
    // Scoreboard. It keeps its own copy of the windows, the run length, the
    // position, the k-mer size and the count table, and it queues the lookups
    // that the query words are due to give.
    // ------------------------------------------------------------------------
    class kmer_tally;
        logic [WIN_W-1:0]    fwd_bases;
        logic [WIN_W-1:0]    rc_bases;
        logic [3:0]          run_len;
        logic [POS_W-1:0]    next_pos;
        logic [KSIZE_W-1:0]  kmer_len;
        bit [COUNT_BITS-1:0] tally [TABLE_DEPTH];
        t_lookup             due_lookups [$];
        int                  mismatches;

        function new();
            fwd_bases  = '0;
            rc_bases   = '0;
            run_len    = '0;
            next_pos   = '0;
            kmer_len   = KSIZE_RESET;
            mismatches = 0;
        endfunction

        function void write_reg(input int idx, input logic [31:0] value);
            if (idx == int'(REG_KMER_SIZE)) begin
                kmer_len = value[KSIZE_W-1:0];
            end
        endfunction

        function int pending();
            return due_lookups.size();
        endfunction

        function void bump(input logic [WIN_W-1:0] idx);
            if (tally[idx] != {COUNT_BITS{1'b1}}) begin
                tally[idx] = tally[idx] + 1'b1;
            end
        endfunction

        // Notes one accepted input word.
        function void take_word(input logic op, input logic first, input logic [7:0] ch);
            logic [1:0]       b;
            logic             ok;
            int unsigned      k;
            logic [WIN_W-1:0] mask;
            logic [WIN_W-1:0] fwd;
            logic [WIN_W-1:0] rev;
            logic [POS_W-1:0] here;
            t_lookup          l;

            if (first) begin
                fwd_bases = '0;
                rc_bases  = '0;
                run_len   = '0;
                next_pos  = '0;
            end
            here     = next_pos;
            next_pos = next_pos + 1'b1;

            ok = 1'b1;
            b  = BASE_A;
            case (ch)
                CH_A_UP, CH_A_LO: b = BASE_A;
                CH_C_UP, CH_C_LO: b = BASE_C;
                CH_G_UP, CH_G_LO: b = BASE_G;
                CH_T_UP, CH_T_LO: b = BASE_T;
                default:          ok = 1'b0;
            endcase
            if (!ok) begin
                fwd_bases = '0;
                rc_bases  = '0;
                run_len   = '0;
                return;
            end

            fwd_bases = {fwd_bases[WIN_W-3:0], b};
            rc_bases  = {~b, rc_bases[WIN_W-1:2]};
            if (run_len != RUN_MAX) run_len = run_len + 1'b1;

            if (kmer_len == 0) k = 1;
            else if (kmer_len > MAX_KMER) k = MAX_KMER;
            else k = kmer_len;
            if (run_len < k) return;

            mask = {WIN_W{1'b1}} >> (2 * (MAX_KMER - k));
            fwd  = fwd_bases & mask;
            rev  = rc_bases >> (2 * (MAX_KMER - k));

            if (op == OP_COUNT) begin
                bump(fwd);
                bump(rev);
                return;
            end

            l.start_pos = here - POS_W'(k) + 1'b1;
            l.kmer      = CODE_W'(fwd);
            l.hits      = COUNT_W'(tally[fwd]);
            l.repeated  = (tally[fwd] > 1);
            due_lookups.push_back(l);
        endfunction

        // Checks one lookup taken from the output channel.
        function void check_lookup(input logic [POS_W-1:0] start_pos,
                                   input logic [CODE_W-1:0] kmer,
                                   input logic [COUNT_W-1:0] hits,
                                   input logic repeated);
            t_lookup l;
            if (due_lookups.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("unexpected lookup: start %0d code %h count %0d repeated %0b",
                             start_pos, kmer, hits, repeated);
                end
                return;
            end
            l = due_lookups.pop_front();
            if (l.start_pos !== start_pos || l.kmer !== kmer ||
                l.hits !== hits || l.repeated !== repeated) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("lookup mismatch: expected start %0d code %h count %0d rep %0b",
                             l.start_pos, l.kmer, l.hits, l.repeated);
                    $display("                 actual   start %0d code %h count %0d rep %0b",
                             start_pos, kmer, hits, repeated);
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals. Every input of the block starts at a known value.
    // ------------------------------------------------------------------------
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic                  i_opcode = OP_COUNT;
    logic                  i_first_of_sequence = 1'b0;
    logic [7:0]            i_base_char = 8'h00;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [POS_W-1:0]      o_start_position;
    logic [CODE_W-1:0]     o_kmer_code;
    logic [COUNT_W-1:0]    o_occurrence_count;
    logic                  o_repeated;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [ADDR_W-1:0]     paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Idle rates of the two channels in percent, changed between phases.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // Long receiver hold-off, started once by the stimulus.
    logic hold_trigger = 1'b0;
    logic hold_off = 1'b0;

    int phase_sizes [10] = '{1, 10, 4, 0, 15, 2, 7, 3, 10, 5};

    kmer_tally lookups = new();

    kmer_occurrence_counter #(
        .MAX_KMER   (MAX_KMER),
        .COUNT_BITS (COUNT_BITS)
    ) dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_opcode            (i_opcode),
        .i_first_of_sequence (i_first_of_sequence),
        .i_base_char         (i_base_char),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_start_position    (o_start_position),
        .o_kmer_code         (o_kmer_code),
        .o_occurrence_count  (o_occurrence_count),
        .o_repeated          (o_repeated),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Output side. The block's outputs are sampled just after the rising edge,
    // before any registered update of that edge lands, so a word counts as
    // taken when valid was high and stall was low at the edge. The stall for
    // the next cycle is then driven with a single nonblocking assignment.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            lookups.check_lookup(o_start_position, o_kmer_code,
                                 o_occurrence_count, o_repeated);
        end
        i_out_stall <= hold_off || ($urandom_range(0, 99) < recv_idle_pct);
    end

    // The long hold-off keeps the receiver stalled for a fixed stretch so that
    // the output register fills and the block has to stall its input.
    initial begin
        do @(posedge i_clk); while (!hold_trigger);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    // Run limit. A correct run ends well before this.
    initial begin
        #(TIMEOUT_NS);
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Driving tasks.
    // ------------------------------------------------------------------------

    function automatic logic [7:0] char_of(input logic [1:0] b, input bit lower);
        logic [7:0] c;
        case (b)
            BASE_A:  c = lower ? CH_A_LO : CH_A_UP;
            BASE_C:  c = lower ? CH_C_LO : CH_C_UP;
            BASE_G:  c = lower ? CH_G_LO : CH_G_UP;
            default: c = lower ? CH_T_LO : CH_T_UP;
        endcase
        return c;
    endfunction

    // Offers one word and returns at the edge at which it is accepted. The
    // valid stays high on return, so the next call either keeps it high with
    // new payload or lowers it for an idle cycle; it is never lowered and
    // raised in the same step.
    task automatic send_word(input logic op, input logic first, input logic [7:0] ch);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid          <= 1'b1;
        i_opcode            <= op;
        i_first_of_sequence <= first;
        i_base_char         <= ch;
        do @(posedge i_clk); while (o_in_stall);
        lookups.take_word(op, first, ch);
    endtask

    // APB write, a setup phase and then an access phase, after which the bus
    // goes idle. The register takes the value at the access edge.
    task automatic apb_write(input int idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx * 4);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        lookups.write_reg(idx, value);
        @(posedge i_clk);
    endtask

    // Stops sending, waits until every predicted lookup is out or the wait limit
    // is reached, then lets the last count word finish its table updates.
    task automatic settle();
        int waited;
        waited = 0;
        i_in_valid <= 1'b0;
        while (lookups.pending() != 0 && waited < SETTLE_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    // Random words, built mostly as sequences that repeat a short motif so
    // that k-mers recur and counts climb. Some sequences carry heavy noise,
    // some continue the previous one without a first flag, and a few bases
    // are swapped at random.
    task automatic run_random(input int n_words);
        int         sent;
        int         motif_len;
        int         seq_len;
        int         noise_pct;
        int         query_pct;
        int         roll;
        logic [1:0] motif [12];
        logic [1:0] b;
        logic [7:0] ch;
        logic       first;
        logic       op;

        sent = 0;
        while (sent < n_words) begin
            motif_len = $urandom_range(1, 12);
            for (int m = 0; m < 12; m++) motif[m] = 2'($urandom_range(0, 3));
            seq_len   = $urandom_range(4, 48);
            noise_pct = ($urandom_range(0, 9) == 0) ? 40 : 4;
            query_pct = $urandom_range(10, 90);
            for (int j = 0; j < seq_len && sent < n_words; j++) begin
                first = ((j == 0) && ($urandom_range(0, 7) != 0)) ||
                        ($urandom_range(0, 199) == 0);
                op    = ($urandom_range(0, 99) < query_pct) ? OP_QUERY : OP_COUNT;
                roll  = $urandom_range(0, 99);
                if (roll < noise_pct) begin
                    ch = 8'($urandom_range(0, 255));
                end else begin
                    b  = (roll >= 92) ? 2'($urandom_range(0, 3)) : motif[j % motif_len];
                    ch = char_of(b, 1'($urandom_range(0, 1)));
                end
                send_word(op, first, ch);
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------------
    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The register is written while the table clear is still running;
        // input words wait on the stall until the clear pass is over.
        send_idle_pct = 37;
        recv_idle_pct = 63;
        apb_write(int'(REG_KMER_SIZE), 32'd2);

        // Two-base windows. AT is its own reverse complement, so counting it
        // adds two to one entry. TG counts CA as its reverse complement.
        send_word(OP_COUNT, 1'b1, CH_A_UP);
        send_word(OP_COUNT, 1'b0, CH_T_UP);
        send_word(OP_COUNT, 1'b0, CH_G_LO);
        // A query with the window not yet full gives nothing.
        send_word(OP_QUERY, 1'b1, CH_A_LO);
        send_word(OP_QUERY, 1'b0, CH_T_LO);
        // Non-base characters empty the window but still move the position.
        send_word(OP_QUERY, 1'b0, 8'h4E);
        send_word(OP_QUERY, 1'b0, CH_C_UP);
        send_word(OP_QUERY, 1'b0, CH_A_LO);
        send_word(OP_QUERY, 1'b0, 8'h00);
        send_word(OP_QUERY, 1'b0, 8'hFF);
        settle();

        // A write to an index past the register list is dropped, and a size
        // of zero behaves as one.
        apb_write(REG_UNUSED, 32'd5);
        apb_write(int'(REG_KMER_SIZE), 32'd0);
        send_word(OP_QUERY, 1'b1, CH_G_UP);
        send_word(OP_QUERY, 1'b0, CH_T_UP);
        settle();

        // Size fifteen clamps to the largest window. Upper data bits of the
        // write are ignored by the four-bit register.
        apb_write(int'(REG_KMER_SIZE), 32'hFFFF_FFFF);
        send_word(OP_COUNT, 1'b1, CH_A_UP);
        send_word(OP_COUNT, 1'b0, CH_C_UP);
        send_word(OP_COUNT, 1'b0, CH_G_UP);
        send_word(OP_COUNT, 1'b0, CH_T_UP);
        send_word(OP_COUNT, 1'b0, CH_T_LO);
        send_word(OP_COUNT, 1'b0, CH_G_LO);
        send_word(OP_COUNT, 1'b0, CH_C_LO);
        send_word(OP_COUNT, 1'b0, CH_A_LO);
        send_word(OP_COUNT, 1'b0, CH_A_UP);
        send_word(OP_QUERY, 1'b0, CH_C_LO);
        settle();

        // Shrinking the size mid-sequence applies at once to the bases that
        // are already in the window.
        apb_write(int'(REG_KMER_SIZE), 32'hFFFF_FFF3);
        send_word(OP_QUERY, 1'b0, CH_G_UP);
        send_word(OP_COUNT, 1'b0, 8'h6E);
        settle();

        // Back pressure: the receiver holds off for a long stretch while the
        // sender keeps offering query words, so the block fills and stalls
        // its input. The settle after it makes the sender pause until every
        // lookup has come out.
        send_idle_pct = 0;
        apb_write(int'(REG_KMER_SIZE), 32'd1);
        hold_trigger <= 1'b1;
        for (int i = 0; i < 60; i++) begin
            send_word(OP_QUERY, i == 0, char_of(2'($urandom_range(0, 3)), 1'b0));
        end
        settle();

        // Random phases over a range of sizes. Idling goes from a slow receiver
        // to a slow sender and ends with neither idling.
        for (int p = 0; p < 10; p++) begin
            if (p < 4) begin
                send_idle_pct = 37;
                recv_idle_pct = 63;
            end else if (p < 7) begin
                send_idle_pct = 63;
                recv_idle_pct = 37;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            apb_write(int'(REG_KMER_SIZE), phase_sizes[p]);
            run_random(WORDS_PER_PHASE);
            settle();
        end

        if (lookups.pending() != 0) begin
            $display("lookups never delivered: %0d", lookups.pending());
        end
        if (lookups.mismatches == 0 && lookups.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
